FILE: sv/rrn_pkg.sv
// ----------------------------------------------------------------------------
// rrn_pkg
// Shared widths and helpers for the ray reflection pipeline.
// ----------------------------------------------------------------------------
package rrn_pkg;

  localparam int unsigned CW = 32;          // component width
  localparam int unsigned PW = 64;          // product / dot width
  localparam int unsigned QW = 34;          // quotient bits produced by the divider
  localparam int unsigned NW = 97;          // numerator width, 2*|v.n|*|n_i|
  localparam int unsigned LAT = QW + 5;     // request to result, in cycles

  typedef struct packed {
    logic              vld;
    logic              degen;
    logic [3*CW-1:0]   inc;
    logic [3*CW-1:0]   hit;
  } side_t;

  // magnitude of a signed component, exact for the most negative value
  function automatic logic [CW-1:0] mag(input logic [CW-1:0] x);
    logic [CW-1:0] m;
    m = x[CW-1] ? (~x + {{(CW-1){1'b0}}, 1'b1}) : x;
    return m;
  endfunction

endpackage

FILE: sv/rrn_dot.sv
// ----------------------------------------------------------------------------
// rrn_dot
// Two-stage signed dot products v.n (as sign and magnitude) and n.n.
// ----------------------------------------------------------------------------
module rrn_dot (
  input  logic                        clk,
  input  logic [3*rrn_pkg::CW-1:0]    inc,
  input  logic [3*rrn_pkg::CW-1:0]    norm,
  output logic [rrn_pkg::PW-1:0]      dmag_r,
  output logic                        dneg_r,
  output logic [rrn_pkg::PW-1:0]      nn_r
);

  logic [rrn_pkg::PW-1:0] vn_r [3];
  logic [rrn_pkg::PW-1:0] sq_r [3];
  logic [2:0]             opp_r;
  logic [rrn_pkg::PW-1:0] pos_nxt, neg_nxt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vn_r[i]  <= rrn_pkg::PW'(rrn_pkg::mag(inc[i*rrn_pkg::CW +: rrn_pkg::CW])) *
                  rrn_pkg::PW'(rrn_pkg::mag(norm[i*rrn_pkg::CW +: rrn_pkg::CW]));
      sq_r[i]  <= rrn_pkg::PW'(rrn_pkg::mag(norm[i*rrn_pkg::CW +: rrn_pkg::CW])) *
                  rrn_pkg::PW'(rrn_pkg::mag(norm[i*rrn_pkg::CW +: rrn_pkg::CW]));
      opp_r[i] <= inc[i*rrn_pkg::CW + rrn_pkg::CW-1] ^ norm[i*rrn_pkg::CW + rrn_pkg::CW-1];
    end
  end

  always_comb begin
    pos_nxt = '0;
    neg_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (opp_r[i]) neg_nxt = neg_nxt + vn_r[i];
      else          pos_nxt = pos_nxt + vn_r[i];
    end
  end

  always_ff @(posedge clk) begin
    dneg_r <= neg_nxt > pos_nxt;
    dmag_r <= (neg_nxt > pos_nxt) ? (neg_nxt - pos_nxt) : (pos_nxt - neg_nxt);
    nn_r   <= sq_r[0] + sq_r[1] + sq_r[2];
  end

endmodule

FILE: sv/rrn_scale.sv
// ----------------------------------------------------------------------------
// rrn_scale
// Two-stage 64x32 product 2*|v.n|*|n_i| built from two 32x32 partials.
// ----------------------------------------------------------------------------
module rrn_scale (
  input  logic                     clk,
  input  logic [rrn_pkg::PW-1:0]   dmag,
  input  logic [rrn_pkg::CW-1:0]   nmag,
  input  logic                     sgn,
  input  logic [rrn_pkg::PW-1:0]   den,
  output logic [rrn_pkg::NW-1:0]   num_r,
  output logic                     sgn_r,
  output logic [rrn_pkg::PW-1:0]   den_r
);

  logic [rrn_pkg::PW-1:0] plo_r, phi_r;
  logic                   sgn1_r;
  logic [rrn_pkg::PW-1:0] den1_r;

  always_ff @(posedge clk) begin
    plo_r  <= rrn_pkg::PW'(dmag[rrn_pkg::CW-1:0]) * rrn_pkg::PW'(nmag);
    phi_r  <= rrn_pkg::PW'(dmag[rrn_pkg::PW-1:rrn_pkg::CW]) * rrn_pkg::PW'(nmag);
    sgn1_r <= sgn;
    den1_r <= den;
  end

  always_ff @(posedge clk) begin
    num_r <= ({1'b0, phi_r, {rrn_pkg::CW{1'b0}}} +
              {{(rrn_pkg::NW-rrn_pkg::PW){1'b0}}, plo_r}) << 1;
    sgn_r <= sgn1_r;
    den_r <= den1_r;
  end

endmodule

FILE: sv/rrn_div.sv
// ----------------------------------------------------------------------------
// rrn_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rrn_div #(
  parameter int unsigned QBITS = rrn_pkg::QW
) (
  input  logic                     clk,
  input  logic [rrn_pkg::NW-1:0]   num,
  input  logic [rrn_pkg::PW-1:0]   den,
  input  logic                     tag,
  output logic [QBITS-1:0]         quo,
  output logic [rrn_pkg::PW-1:0]   rem,
  output logic [rrn_pkg::PW-1:0]   den_o,
  output logic                     tag_o
);

  logic [rrn_pkg::PW-1:0] rem_r [QBITS];
  logic [QBITS-1:0]       low_r [QBITS];
  logic [QBITS-1:0]       quo_r [QBITS];
  logic [rrn_pkg::PW-1:0] den_r [QBITS];
  logic                   tag_r [QBITS];

  for (genvar s = 0; s < QBITS; s++) begin : g_st
    logic [rrn_pkg::PW-1:0] rin, din;
    logic [QBITS-1:0]       lin, qin;
    logic                   tin;
    logic [rrn_pkg::PW:0]   tr;
    logic                   ge;

    if (s == 0) begin : g_first
      assign rin = rrn_pkg::PW'(num[rrn_pkg::NW-1:QBITS]);
      assign lin = num[QBITS-1:0];
      assign qin = '0;
      assign din = den;
      assign tin = tag;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign lin = low_r[s-1];
      assign qin = quo_r[s-1];
      assign din = den_r[s-1];
      assign tin = tag_r[s-1];
    end

    assign tr = {rin, lin[QBITS-1]};
    assign ge = tr >= {1'b0, din};

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? rrn_pkg::PW'(tr - {1'b0, din}) : tr[rrn_pkg::PW-1:0];
      low_r[s] <= lin << 1;
      quo_r[s] <= {qin[QBITS-2:0], ge};
      den_r[s] <= din;
      tag_r[s] <= tin;
    end
  end

  assign quo   = quo_r[QBITS-1];
  assign rem   = rem_r[QBITS-1];
  assign den_o = den_r[QBITS-1];
  assign tag_o = tag_r[QBITS-1];

endmodule

FILE: sv/ray_reflect_about_normal_unit.sv
// ----------------------------------------------------------------------------
// ray_reflect_about_normal_unit
// Mirrors an incident direction about a surface normal's plane: r = v - 2(v.n)n/(n.n).
// ----------------------------------------------------------------------------
// throughput: one request per cycle; busy is always low
// the 34-stage quotient pipeline sets the latency
// reset clears the valid bits only; results cannot be stalled
module ray_reflect_about_normal_unit #(
  parameter int unsigned QBITS = rrn_pkg::QW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [rrn_pkg::CW-1:0]   in_inc_x,
  input  logic [rrn_pkg::CW-1:0]   in_inc_y,
  input  logic [rrn_pkg::CW-1:0]   in_inc_z,
  input  logic [rrn_pkg::CW-1:0]   in_norm_x,
  input  logic [rrn_pkg::CW-1:0]   in_norm_y,
  input  logic [rrn_pkg::CW-1:0]   in_norm_z,
  input  logic [rrn_pkg::CW-1:0]   in_hit_x,
  input  logic [rrn_pkg::CW-1:0]   in_hit_y,
  input  logic [rrn_pkg::CW-1:0]   in_hit_z,
  output logic                     out_valid,
  output logic [rrn_pkg::CW-1:0]   out_origin_x,
  output logic [rrn_pkg::CW-1:0]   out_origin_y,
  output logic [rrn_pkg::CW-1:0]   out_origin_z,
  output logic [rrn_pkg::CW-1:0]   out_refl_x,
  output logic [rrn_pkg::CW-1:0]   out_refl_y,
  output logic [rrn_pkg::CW-1:0]   out_refl_z,
  output logic                     out_degenerate
);

  localparam int unsigned CW  = rrn_pkg::CW;
  localparam int unsigned LAT = QBITS + 5;

  logic [3*CW-1:0]        inc, norm;
  logic [rrn_pkg::PW-1:0] dmag, nn;
  logic                   dneg;
  logic [2:0]             nneg_r [2];
  logic [CW-1:0]          nmag_r [2][3];
  rrn_pkg::side_t         side_r [LAT-1];
  rrn_pkg::side_t         side_in;

  logic [rrn_pkg::NW-1:0] num   [3];
  logic                   sgn   [3];
  logic [rrn_pkg::PW-1:0] sden  [3];
  logic [QBITS-1:0]       quo   [3];
  logic [rrn_pkg::PW-1:0] rem   [3];
  logic [rrn_pkg::PW-1:0] dden  [3];
  logic                   dsgn  [3];
  logic [CW-1:0]          refl_nxt [3];

  assign busy = 1'b0;
  assign inc  = {in_inc_z, in_inc_y, in_inc_x};
  assign norm = {in_norm_z, in_norm_y, in_norm_x};

  assign side_in.vld   = start;
  assign side_in.degen = (inc == '0) || (norm == '0);
  assign side_in.inc   = inc;
  assign side_in.hit   = {in_hit_z, in_hit_y, in_hit_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT-1; k++) side_r[k].vld <= 1'b0;
    end else begin
      side_r[0].vld <= side_in.vld;
      for (int k = 1; k < LAT-1; k++) side_r[k].vld <= side_r[k-1].vld;
    end
    side_r[0].degen <= side_in.degen;
    side_r[0].inc   <= side_in.inc;
    side_r[0].hit   <= side_in.hit;
    for (int k = 1; k < LAT-1; k++) begin
      side_r[k].degen <= side_r[k-1].degen;
      side_r[k].inc   <= side_r[k-1].inc;
      side_r[k].hit   <= side_r[k-1].hit;
    end
  end

  // normal signs and magnitudes line up with the dot product output
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nneg_r[0][i] <= norm[i*CW + CW-1];
      nmag_r[0][i] <= rrn_pkg::mag(norm[i*CW +: CW]);
    end
    nneg_r[1] <= nneg_r[0];
    nmag_r[1] <= nmag_r[0];
  end

  rrn_dot u_dot (
    .clk    (clk),
    .inc    (inc),
    .norm   (norm),
    .dmag_r (dmag),
    .dneg_r (dneg),
    .nn_r   (nn)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [QBITS:0] qr;
    logic [CW+3:0]  vx, diff;

    rrn_scale u_scale (
      .clk   (clk),
      .dmag  (dmag),
      .nmag  (nmag_r[1][i]),
      .sgn   (dneg ^ nneg_r[1][i]),
      .den   (nn),
      .num_r (num[i]),
      .sgn_r (sgn[i]),
      .den_r (sden[i])
    );

    rrn_div #(.QBITS(QBITS)) u_div (
      .clk   (clk),
      .num   (num[i]),
      .den   (sden[i]),
      .tag   (sgn[i]),
      .quo   (quo[i]),
      .rem   (rem[i]),
      .den_o (dden[i]),
      .tag_o (dsgn[i])
    );

    // round half away from zero, then apply the sign and saturate
    assign qr = {1'b0, quo[i]} +
                (QBITS+1)'({1'b0, rem[i]} >= {1'b0, dden[i]} - {1'b0, rem[i]});
    assign vx = (CW+4)'(signed'(side_r[LAT-2].inc[i*CW +: CW]));
    assign diff = dsgn[i] ? vx + (CW+4)'(qr) : vx - (CW+4)'(qr);

    always_comb begin
      if (side_r[LAT-2].degen)
        refl_nxt[i] = '0;
      else if (!diff[CW+3] && diff[CW+2:CW-1] != '0)
        refl_nxt[i] = {1'b0, {(CW-1){1'b1}}};
      else if (diff[CW+3] && diff[CW+2:CW-1] != '1)
        refl_nxt[i] = {1'b1, {(CW-1){1'b0}}};
      else
        refl_nxt[i] = diff[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= side_r[LAT-2].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_origin_x   <= side_r[LAT-2].hit[0*CW +: CW];
    out_origin_y   <= side_r[LAT-2].hit[1*CW +: CW];
    out_origin_z   <= side_r[LAT-2].hit[2*CW +: CW];
    out_refl_x     <= refl_nxt[0];
    out_refl_y     <= refl_nxt[1];
    out_refl_z     <= refl_nxt[2];
    out_degenerate <= side_r[LAT-2].degen;
  end

  a_lat : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid) else $error("request did not produce a result");
  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_refl_x == '0 && out_refl_y == '0 && out_refl_z == '0)
    else $error("degenerate result carries a direction");
  a_deg_in : assert property (@(posedge clk) disable iff (!rst_n)
    start && in_inc_x == '0 && in_inc_y == '0 && in_inc_z == '0 |-> ##LAT out_degenerate)
    else $error("zero incident vector not flagged");
  a_hit : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_origin_x == $past(in_hit_x, LAT))
    else $error("origin does not match hit point");

endmodule
